>>> sv/point_in_polygon_test_top_defines.svh
// assertion macros for the point in polygon block
`ifndef POINT_IN_POLYGON_TEST_TOP_DEFINES_SVH
`define POINT_IN_POLYGON_TEST_TOP_DEFINES_SVH

`ifndef SYNTH
// check on every clock edge outside reset
`define PIP_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("point in polygon assertion failed");
// check on every clock edge, reset included
`define PIP_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) (prop)) \
    else $error("point in polygon assertion failed");
`else
`define PIP_ASSERT(label, prop)
`define PIP_ASSERT_ALWAYS(label, prop)
`endif

`endif

>>> sv/pip_pkg.sv
package pip_pkg;

  // store size and derived widths
  localparam int MAX_VERTICES = 256;
  localparam int ADDR_W       = $clog2(MAX_VERTICES);
  localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
  localparam int RD_W         = $clog2(MAX_VERTICES + 2);

  // field widths
  localparam int OP_W      = 2;
  localparam int COORD_W   = 16;
  localparam int OUT_CNT_W = 9;
  localparam int FRAC_BITS = 4;
  localparam int DIFF_W    = COORD_W + 1;
  localparam int PROD_W    = 2 * DIFF_W;

  // operation codes
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
  localparam logic [OP_W-1:0] OP_APPEND = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
  } vertex_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  // control from the sequencer to the edge unit
  typedef struct packed {
    logic start;
    logic rd_valid;
  } edge_ctl_t;

  // status back from the edge unit
  typedef struct packed {
    logic busy;
    logic parity;
  } edge_sts_t;

endpackage

>>> sv/pip_if.sv
// command channel
interface pip_in_if;
  logic                                 valid;
  logic                                 ready;
  logic [pip_pkg::OP_W-1:0]             opcode;
  logic signed [pip_pkg::COORD_W-1:0]   coord_x;
  logic signed [pip_pkg::COORD_W-1:0]   coord_y;

  modport source (output valid, output opcode, output coord_x, output coord_y, input ready);
  modport sink   (input valid, input opcode, input coord_x, input coord_y, output ready);
endinterface

// result channel
interface pip_out_if;
  logic                             valid;
  logic                             ready;
  logic                             inside_res;
  logic [pip_pkg::OUT_CNT_W-1:0]    stored_vertices;
  logic                             store_full;

  modport source (output valid, output inside_res, output stored_vertices,
                  output store_full, input ready);
  modport sink   (input valid, input inside_res, input stored_vertices,
                  input store_full, output ready);
endinterface

>>> sv/pip_vertex_ram.sv
// single port pair vertex memory, registered read
module pip_vertex_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, registered
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> sv/pip_edge_unit.sv
`include "point_in_polygon_test_top_defines.svh"

// sliding vertex window and crossing test pipeline
module pip_edge_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  input  pip_pkg::edge_ctl_t                 ctl,
  input  logic signed [pip_pkg::COORD_W-1:0] q_x,
  input  logic signed [pip_pkg::COORD_W-1:0] q_y,
  input  pip_pkg::vertex_t                   rd_data,
  output pip_pkg::edge_sts_t                 sts
);

  localparam int DW = pip_pkg::DIFF_W;
  localparam int PW = pip_pkg::PROD_W;
  localparam int FB = pip_pkg::FRAC_BITS;

  function automatic logic between(input logic signed [pip_pkg::COORD_W-1:0] q,
                                   input logic signed [pip_pkg::COORD_W-1:0] a,
                                   input logic signed [pip_pkg::COORD_W-1:0] b);
    return ((q > a) && (q < b)) || ((q < a) && (q > b));
  endfunction

  logic signed [pip_pkg::COORD_W-1:0] qx_r, qy_r;
  pip_pkg::vertex_t                   w0_r, w1_r;
  logic [1:0]                         fill_r, fill_nxt;

  logic                 s1_valid_r, s1_valid_nxt;
  logic signed [DW-1:0] s1_dxq_r, s1_dcut_r, s1_dyq_r, s1_dxe_r;
  logic                 s1_btw_r, s1_dir_r, s1_vtx_r;

  logic                 s2_valid_r, s2_valid_nxt;
  logic signed [PW-1:0] s2_lhs_r, s2_rhs_r;
  logic                 s2_btw_r, s2_dir_r, s2_vtx_r;

  logic                 parity_r, parity_nxt;

  logic signed [DW-1:0] dy, dy_adj, dcut;
  logic                 above;

  // y span of the edge cut toward zero to a whole unit
  always_comb begin
    dy     = DW'(w1_r.y) - DW'(w0_r.y);
    dy_adj = dy[DW-1] ? (dy + DW'((1 << FB) - 1)) : dy;
    dcut   = {dy_adj[DW-1:FB], {FB{1'b0}}};
  end

  // window fill and stage valids
  always_comb begin
    fill_nxt     = fill_r;
    s1_valid_nxt = 1'b0;
    if (ctl.start) begin
      fill_nxt = 2'd0;
    end else if (ctl.rd_valid) begin
      if (fill_r == 2'd2) begin
        s1_valid_nxt = 1'b1;
      end else begin
        fill_nxt = fill_r + 2'd1;
      end
    end
    s2_valid_nxt = s1_valid_r;
  end

  // crossing decision and parity
  always_comb begin
    above      = s2_dir_r ? (s2_lhs_r > s2_rhs_r) : (s2_lhs_r < s2_rhs_r);
    parity_nxt = parity_r;
    if (ctl.start) begin
      parity_nxt = 1'b0;
    end else if (s2_valid_r) begin
      parity_nxt = parity_r ^ (s2_btw_r & above) ^ s2_vtx_r;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r     <= 2'd0;
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      parity_r   <= 1'b0;
    end else begin
      fill_r     <= fill_nxt;
      s1_valid_r <= s1_valid_nxt;
      s2_valid_r <= s2_valid_nxt;
      parity_r   <= parity_nxt;
    end
  end

  // query point, window and stage payload
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      qx_r <= q_x;
      qy_r <= q_y;
    end
    if (ctl.rd_valid) begin
      w0_r <= w1_r;
      w1_r <= rd_data;
      // edge (w0, w1) with the vertex after it now arriving
      s1_dxq_r  <= DW'(qx_r) - DW'(w0_r.x);
      s1_dcut_r <= dcut;
      s1_dyq_r  <= DW'(qy_r) - DW'(w0_r.y);
      s1_dxe_r  <= DW'(w1_r.x) - DW'(w0_r.x);
      s1_btw_r  <= between(qx_r, w0_r.x, w1_r.x);
      s1_dir_r  <= w1_r.x > w0_r.x;
      s1_vtx_r  <= (w1_r.x == qx_r) && between(qx_r, w0_r.x, rd_data.x) && (w1_r.y > qy_r);
    end
    s2_lhs_r <= s1_dxq_r * s1_dcut_r;
    s2_rhs_r <= s1_dyq_r * s1_dxe_r;
    s2_btw_r <= s1_btw_r;
    s2_dir_r <= s1_dir_r;
    s2_vtx_r <= s1_vtx_r;
  end

  assign sts.busy   = s1_valid_r | s2_valid_r;
  assign sts.parity = parity_r;

  `PIP_ASSERT(a_s2_follows_s1, s2_valid_r |-> $past(s1_valid_r))
  `PIP_ASSERT(a_start_when_empty, ctl.start |-> (!s1_valid_r && !s2_valid_r))
  `PIP_ASSERT(a_start_not_reading, ctl.start |-> !ctl.rd_valid)

endmodule

>>> sv/point_in_polygon_test_top.sv
// Point in polygon test over a store of up to pip_pkg::MAX_VERTICES vertices
// held in one vertex memory. Clear and append pass from the transfer through
// the finish state to the output register. A query with n stored vertices
// walks the ring once through the memory read port, one vertex per cycle,
// reading n + 2 vertices to close the ring, then drains a window, multiply and
// compare pipeline. A query with fewer than two vertices answers outside. One
// command is in flight at a time; a result waits in the output register while
// the next command is taken.
`include "point_in_polygon_test_top_defines.svh"

module point_in_polygon_test_top (
  input  logic       clk,
  input  logic       rst_n,
  pip_in_if.sink     in_ch,
  pip_out_if.source  out_ch
);

  localparam int AW  = pip_pkg::ADDR_W;
  localparam int CW  = pip_pkg::CNT_W;
  localparam int RW  = pip_pkg::RD_W;

  pip_pkg::state_t       state_r, state_nxt;
  logic [CW-1:0]         total_r;
  logic [RW-1:0]         rd_cnt_r;
  logic                  rd_valid_r;
  logic                  walked_r;
  logic                  res_full_r;

  logic                  out_valid_r;
  logic                  out_inside_r;
  logic [pip_pkg::OUT_CNT_W-1:0] out_count_r;
  logic                  out_full_r;

  logic                  accept, rd_en, walk_last, out_load, do_walk, room;
  logic [AW-1:0]         rd_addr;
  logic [RW-1:0]         total_ext;
  pip_pkg::vertex_t      wr_vertex, rd_vertex;
  pip_pkg::edge_ctl_t    edge_ctl;
  pip_pkg::edge_sts_t    edge_sts;

  assign accept    = in_ch.valid & in_ch.ready;
  assign total_ext = RW'(total_r);
  assign room      = total_r < CW'(pip_pkg::MAX_VERTICES);
  assign do_walk   = (in_ch.opcode == pip_pkg::OP_QUERY) && (total_r > CW'(1));
  assign walk_last = rd_cnt_r == (total_ext + RW'(1));

  // ring address: the first two vertices come again to close the ring
  assign rd_addr = (rd_cnt_r < total_ext) ? AW'(rd_cnt_r) : AW'(rd_cnt_r - total_ext);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      pip_pkg::ST_IDLE: begin
        if (accept) begin
          state_nxt = do_walk ? pip_pkg::ST_WALK : pip_pkg::ST_FINISH;
        end
      end
      pip_pkg::ST_WALK: begin
        if (walk_last) begin
          state_nxt = pip_pkg::ST_DRAIN;
        end
      end
      pip_pkg::ST_DRAIN: begin
        if (!rd_valid_r && !edge_sts.busy) begin
          state_nxt = pip_pkg::ST_FINISH;
        end
      end
      pip_pkg::ST_FINISH: begin
        if (!out_valid_r || out_ch.ready) begin
          state_nxt = pip_pkg::ST_IDLE;
        end
      end
      default: state_nxt = pip_pkg::ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_ch.ready = 1'b0;
    rd_en       = 1'b0;
    out_load    = 1'b0;
    unique case (state_r)
      pip_pkg::ST_IDLE:   in_ch.ready = 1'b1;
      pip_pkg::ST_WALK:   rd_en       = 1'b1;
      pip_pkg::ST_DRAIN:  ;
      pip_pkg::ST_FINISH: out_load    = !out_valid_r || out_ch.ready;
      default:            ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pip_pkg::ST_IDLE;
      total_r     <= '0;
      rd_cnt_r    <= '0;
      rd_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      rd_valid_r <= rd_en;
      if (accept) begin
        rd_cnt_r <= '0;
        case (in_ch.opcode)
          pip_pkg::OP_CLEAR:  total_r <= '0;
          pip_pkg::OP_APPEND: if (room) total_r <= total_r + CW'(1);
          default:            ;
        endcase
      end else if (rd_en) begin
        rd_cnt_r <= rd_cnt_r + RW'(1);
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // per command result fields and output payload
  always_ff @(posedge clk) begin
    if (accept) begin
      walked_r   <= do_walk;
      res_full_r <= (in_ch.opcode == pip_pkg::OP_APPEND) && !room;
    end
    if (out_load) begin
      out_inside_r <= walked_r & edge_sts.parity;
      out_count_r  <= pip_pkg::OUT_CNT_W'(total_r);
      out_full_r   <= res_full_r;
    end
  end

  // vertex memory, appends and query reads never share a cycle
  assign wr_vertex.x = in_ch.coord_x;
  assign wr_vertex.y = in_ch.coord_y;

  pip_vertex_ram #(
    .DEPTH (pip_pkg::MAX_VERTICES),
    .WIDTH ($bits(pip_pkg::vertex_t))
  ) u_ram (
    .clk   (clk),
    .we    (accept && (in_ch.opcode == pip_pkg::OP_APPEND) && room),
    .waddr (AW'(total_r)),
    .wdata (wr_vertex),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_vertex)
  );

  assign edge_ctl.start    = accept && do_walk;
  assign edge_ctl.rd_valid = rd_valid_r;

  pip_edge_unit u_edge (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (edge_ctl),
    .q_x     (in_ch.coord_x),
    .q_y     (in_ch.coord_y),
    .rd_data (rd_vertex),
    .sts     (edge_sts)
  );

  assign out_ch.valid           = out_valid_r;
  assign out_ch.inside_res      = out_inside_r;
  assign out_ch.stored_vertices = out_count_r;
  assign out_ch.store_full      = out_full_r;

  `PIP_ASSERT(a_count_max, total_r <= CW'(pip_pkg::MAX_VERTICES))
  `PIP_ASSERT(a_read_in_store, rd_en |-> (RW'(rd_addr) < total_ext))
  `PIP_ASSERT(a_count_steady_walk, (state_r == pip_pkg::ST_WALK) |=> $stable(total_r))
  `PIP_ASSERT(a_finish_drained,
              (state_r == pip_pkg::ST_DRAIN && state_nxt == pip_pkg::ST_FINISH) |-> !edge_sts.busy)

endmodule

>>> tb/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TAIL_ITEMS  = 120;
  localparam int HOLD_CYCLES = 400;

  typedef struct packed {
    logic [pip_pkg::OP_W-1:0]           op;
    logic signed [pip_pkg::COORD_W-1:0] x;
    logic signed [pip_pkg::COORD_W-1:0] y;
  } command_t;

  typedef struct packed {
    logic                          in_poly;
    logic [pip_pkg::OUT_CNT_W-1:0] count;
    logic                          full;
  } answer_t;

  logic clk = 1'b0;
  logic rst_n;

  pip_in_if  in_ch ();
  pip_out_if out_ch ();

  point_in_polygon_test_top uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // free running clock
  always #10ns clk = ~clk;

  // commands waiting to be sent and answers waiting to come back
  command_t cmd_q[$];
  answer_t  answer_q[$];

  // generator view of the ring, used to aim query points
  int gen_x[$];
  int gen_y[$];

  // predicted vertex store
  logic signed [pip_pkg::COORD_W-1:0] vtx_x [0:pip_pkg::MAX_VERTICES-1];
  logic signed [pip_pkg::COORD_W-1:0] vtx_y [0:pip_pkg::MAX_VERTICES-1];
  int vtx_total;

  // run statistics
  int n_total, n_accepted, n_results, n_errors;
  int n_queries, n_inside, n_dropped, peak_total;

  // handshake control
  command_t cur_cmd;
  int       tx_gap, rx_gap;
  bit       tx_idle_en = 1'b1;
  bit       rx_idle_en = 1'b1;
  logic     tail_phase = 1'b0;
  logic     long_hold  = 1'b0;
  answer_t  seen, want;

  // ---------------------------------------------------------------------------
  // prediction

  function automatic bit strictly_inside_span(input longint q, input longint a,
                                              input longint b);
    return (q > a && q < b) || (q < a && q > b);
  endfunction

  // crossing parity of the stored ring for one query point
  function automatic logic ring_parity(input logic signed [pip_pkg::COORD_W-1:0] qx,
                                       input logic signed [pip_pkg::COORD_W-1:0] qy);
    int unsigned hits;
    int          j, k;
    longint      lqx, lqy, px, py, nx, ny, ax, dy, lhs, rhs;
    bit          above;
    hits = 0;
    lqx  = qx;
    lqy  = qy;
    if (vtx_total <= 1) return 1'b0;
    for (int i = 0; i < vtx_total; i++) begin
      j  = (i + 1) % vtx_total;
      k  = (j + 1) % vtx_total;
      px = vtx_x[i];
      py = vtx_y[i];
      nx = vtx_x[j];
      ny = vtx_y[j];
      ax = vtx_x[k];
      // edge crossing, y step cut toward zero to a whole unit
      if (strictly_inside_span(lqx, px, nx)) begin
        dy    = ((ny - py) / 16) * 16;
        lhs   = (lqx - px) * dy;
        rhs   = (lqy - py) * (nx - px);
        above = (nx > px) ? (lhs > rhs) : (lhs < rhs);
        if (above) hits++;
      end
      // vertex sitting on the query column with straddling neighbors
      if (nx == lqx && strictly_inside_span(lqx, px, ax) && ny > lqy) hits++;
    end
    return hits[0];
  endfunction

  // update the predicted store and queue the expected answer
  function automatic void track_command(input command_t c);
    answer_t a;
    a = '0;
    case (c.op)
      pip_pkg::OP_CLEAR: vtx_total = 0;
      pip_pkg::OP_APPEND: begin
        if (vtx_total < pip_pkg::MAX_VERTICES) begin
          vtx_x[vtx_total] = c.x;
          vtx_y[vtx_total] = c.y;
          vtx_total++;
          if (vtx_total > peak_total) peak_total = vtx_total;
        end else begin
          a.full = 1'b1;
          n_dropped++;
        end
      end
      pip_pkg::OP_QUERY: begin
        a.in_poly = ring_parity(c.x, c.y);
        n_queries++;
        if (a.in_poly) n_inside++;
      end
      default: ;
    endcase
    a.count = pip_pkg::OUT_CNT_W'(vtx_total);
    answer_q.push_back(a);
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus

  function automatic int rand16();
    return int'($urandom_range(0, 65535)) - 32768;
  endfunction

  function automatic int extreme_coord();
    case ($urandom_range(0, 5))
      0:       return -32768;
      1:       return -32767;
      2:       return 32767;
      3:       return 32766;
      4:       return 0;
      default: return rand16();
    endcase
  endfunction

  // query coordinate aimed at the current ring
  function automatic int near_coord(input bit of_x);
    int a, b, va, vb, pick;
    if (gen_x.size() == 0) return rand16();
    a    = $urandom_range(0, gen_x.size() - 1);
    b    = $urandom_range(0, gen_x.size() - 1);
    va   = of_x ? gen_x[a] : gen_y[a];
    vb   = of_x ? gen_x[b] : gen_y[b];
    pick = $urandom_range(0, 9);
    if (pick < 4) return va;
    if (pick < 6) return va + int'($urandom_range(0, 32)) - 16;
    if (pick < 9) return (va + vb) / 2 + int'($urandom_range(0, 2)) - 1;
    return rand16();
  endfunction

  task automatic queue_command(input logic [pip_pkg::OP_W-1:0] op, input int x,
                               input int y);
    command_t c;
    c.op = op;
    c.x  = x[pip_pkg::COORD_W-1:0];
    c.y  = y[pip_pkg::COORD_W-1:0];
    cmd_q.push_back(c);
    if (op == pip_pkg::OP_CLEAR) begin
      gen_x.delete();
      gen_y.delete();
    end else if (op == pip_pkg::OP_APPEND && gen_x.size() < pip_pkg::MAX_VERTICES) begin
      gen_x.push_back(c.x);
      gen_y.push_back(c.y);
    end
  endtask

  // clear, build a ring of n_vtx vertices, then ask about it
  task automatic polygon_run(input int n_vtx, input int n_ask);
    int mode, ox, oy, step, span;
    mode = $urandom_range(0, 3);
    step = 1 << $urandom_range(0, 8);
    span = $urandom_range(2, 12);
    ox   = int'($urandom_range(0, 58000)) - 29000;
    oy   = int'($urandom_range(0, 58000)) - 29000;
    queue_command(pip_pkg::OP_CLEAR, rand16(), rand16());
    for (int i = 0; i < n_vtx; i++) begin
      case (mode)
        0: queue_command(pip_pkg::OP_APPEND, rand16(), rand16());
        3: queue_command(pip_pkg::OP_APPEND, extreme_coord(), extreme_coord());
        default: queue_command(pip_pkg::OP_APPEND,
                               ox + (int'($urandom_range(0, 2 * span)) - span) * step,
                               oy + (int'($urandom_range(0, 2 * span)) - span) * step);
      endcase
    end
    for (int i = 0; i < n_ask; i++)
      queue_command(pip_pkg::OP_QUERY, near_coord(1'b1), near_coord(1'b0));
  endtask

  // unordered commands on whatever the store holds
  task automatic noise_burst();
    int len;
    len = $urandom_range(1, 8);
    repeat (len) begin
      case ($urandom_range(0, 4))
        0:       queue_command(pip_pkg::OP_CLEAR, rand16(), rand16());
        1, 2:    queue_command(pip_pkg::OP_APPEND, rand16(), rand16());
        default: queue_command(pip_pkg::OP_QUERY, near_coord(1'b1), near_coord(1'b0));
      endcase
    end
  endtask

  // ---------------------------------------------------------------------------
  // driver: offers queued commands, updates the prediction on each transfer

  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        track_command(cur_cmd);
        n_accepted++;
      end
      // an offer stays up until taken
      if (!in_ch.valid || in_ch.ready) begin
        if ($urandom_range(0, 299) == 0) tx_idle_en = !tx_idle_en;
        if (tx_gap > 0) begin
          tx_gap--;
          in_ch.valid <= 1'b0;
        end else if (cmd_q.size() > 0) begin
          cur_cmd = cmd_q.pop_front();
          in_ch.valid   <= 1'b1;
          in_ch.opcode  <= cur_cmd.op;
          in_ch.coord_x <= cur_cmd.x;
          in_ch.coord_y <= cur_cmd.y;
          if (tx_idle_en && !tail_phase && $urandom_range(0, 7) == 0)
            tx_gap = $urandom_range(1, 17);
        end else begin
          in_ch.valid <= 1'b0;
        end
        tail_phase <= (cmd_q.size() < TAIL_ITEMS);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: checks each result transfer against the oldest answer

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        seen.in_poly = out_ch.inside_res;
        seen.count   = out_ch.stored_vertices;
        seen.full    = out_ch.store_full;
        n_results++;
        if (answer_q.size() == 0) begin
          n_errors++;
          $display("%0t: unexpected result inside_res %0b stored_vertices %0d store_full %0b",
                   $time, seen.in_poly, seen.count, seen.full);
        end else begin
          want = answer_q.pop_front();
          if (seen !== want) begin
            n_errors++;
            $display("%0t: mismatch expected inside_res %0b stored_vertices %0d store_full %0b",
                     $time, want.in_poly, want.count, want.full);
            $display("%0t:          actual   inside_res %0b stored_vertices %0d store_full %0b",
                     $time, seen.in_poly, seen.count, seen.full);
          end
        end
      end
      // receiver stalls
      if ($urandom_range(0, 299) == 0) rx_idle_en = !rx_idle_en;
      if (long_hold) begin
        out_ch.ready <= 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        if (rx_idle_en && !tail_phase && $urandom_range(0, 9) == 0)
          rx_gap = $urandom_range(1, 17);
      end
    end
  end

  // long receiver hold-off so the block backs up into its input
  initial begin
    wait (n_accepted >= 300);
    @(posedge clk);
    long_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    long_hold <= 1'b0;
  end

  // run limit
  initial begin
    #60ms;
    $display("Some tests failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // main sequence

  initial begin
    int seq, sel;
    rst_n         = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.opcode  = pip_pkg::OP_CLEAR;
    in_ch.coord_x = '0;
    in_ch.coord_y = '0;
    out_ch.ready  = 1'b0;
    vtx_total     = 0;

    // directed: empty and short rings, extreme coordinates
    queue_command(pip_pkg::OP_QUERY, 0, 0);
    queue_command(pip_pkg::OP_CLEAR, -32768, 32767);
    queue_command(pip_pkg::OP_APPEND, -32768, -32768);
    queue_command(pip_pkg::OP_QUERY, -32768, 0);
    queue_command(pip_pkg::OP_APPEND, 32767, 32767);
    queue_command(pip_pkg::OP_QUERY, 0, -32768);
    queue_command(pip_pkg::OP_APPEND, 32767, -32768);
    queue_command(pip_pkg::OP_QUERY, 32766, -32767);
    queue_command(pip_pkg::OP_QUERY, -32768, 32767);
    // directed: apex on the query column
    queue_command(pip_pkg::OP_CLEAR, 0, 0);
    queue_command(pip_pkg::OP_APPEND, 0, 160);
    queue_command(pip_pkg::OP_APPEND, -160, -160);
    queue_command(pip_pkg::OP_APPEND, 160, -160);
    queue_command(pip_pkg::OP_QUERY, 0, 0);
    queue_command(pip_pkg::OP_QUERY, 0, 200);
    queue_command(pip_pkg::OP_QUERY, 160, -200);
    queue_command(pip_pkg::OP_QUERY, -159, -150);
    // directed: sloped edges whose y step is not a whole unit
    queue_command(pip_pkg::OP_CLEAR, 0, 0);
    queue_command(pip_pkg::OP_APPEND, 0, 0);
    queue_command(pip_pkg::OP_APPEND, 32, 31);
    queue_command(pip_pkg::OP_APPEND, 32, -31);
    queue_command(pip_pkg::OP_QUERY, 16, 10);
    queue_command(pip_pkg::OP_QUERY, 16, -10);
    queue_command(pip_pkg::OP_QUERY, 31, 14);

    // random: mostly well formed rings, some noise, two full store runs
    seq = 0;
    while (cmd_q.size() < 1500) begin
      sel = $urandom_range(0, 99);
      if (seq == 3 || seq == 70) polygon_run(pip_pkg::MAX_VERTICES + $urandom_range(1, 3), 3);
      else if (sel < 72) polygon_run($urandom_range(3, 12), $urandom_range(1, 6));
      else if (sel < 80) polygon_run($urandom_range(13, 60), $urandom_range(1, 4));
      else if (sel < 87) polygon_run($urandom_range(0, 2), $urandom_range(1, 3));
      else noise_burst();
      seq++;
    end
    n_total = cmd_q.size();

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    while (n_accepted < n_total) @(posedge clk);
    while (answer_q.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);

    $display("sent %0d commands, %0d queries (%0d inside), %0d appends dropped at a full store",
             n_total, n_queries, n_inside, n_dropped);
    $display("largest ring %0d vertices, %0d results checked, %0d mismatches",
             peak_total, n_results, n_errors);
    if (n_errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

>>> point_in_polygon_test_top.f
+incdir+sv
sv/pip_pkg.sv
sv/pip_if.sv
sv/pip_vertex_ram.sv
sv/pip_edge_unit.sv
sv/point_in_polygon_test_top.sv
tb/tb_top.sv
